/* rtl/rvx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// types and constants shared by the rv32im execute unit
// ----------------------------------------------------------------------------
package rvx_pkg;

  // data memory size in 32-bit words, a power of two
  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned NUM_REGS  = 32;

  typedef enum logic [5:0] {
    OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU,
    OP_BGEU, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW, OP_ADDI,
    OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI,
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR,
    OP_AND, OP_FENCE, OP_FENCE_TSO, OP_PAUSE, OP_ECALL, OP_EBREAK, OP_MUL,
    OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MEM, S_DIV, S_FIN
  } state_t;

  typedef struct packed {
    logic [5:0]         req_type;
    logic [4:0]         dest_index;
    logic [4:0]         src1_index;
    logic [4:0]         src2_index;
    logic signed [31:0] immediate;
  } req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [31:0] written_value;
    logic        illegal_op;
  } rsp_t;

endpackage

/* rtl/rv32im_execute_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_execute_unit_top
// executes decoded rv32im instructions against pc, register file and memory
// ----------------------------------------------------------------------------
// usage
//   req channel: one decoded instruction per item (req_valid / req_stall)
//   rsp channel: one result per item (rsp_valid / rsp_stall): next pc,
//   register write-back and the illegal-opcode flag
//   items are worked one at a time; the register file and the byte-lane
//   data memory are synchronous rams with registered read data
//   alu, branch and multiply items go from exec to fin; loads and stores
//   go through mem (load data capture, spill word of a store), divide and
//   remainder through div (radix-2 restoring divider, 32 steps)
//   a new item is taken in the cycle after the previous result is loaded
//   into the output register, so no item is taken before the last is done
//   the output register lets the next item be accepted and worked while
//   a result still waits on a stalled receiver; the block holds in its
//   final state only if a second result is ready before the first is taken
//   reset clears pc and all register valid bits (registers read as zero);
//   the data memory is not cleared and must be written before it is read
// ----------------------------------------------------------------------------
module rv32im_execute_unit_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rvx_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rvx_pkg::rsp_t rsp
);

  localparam int unsigned AW = rvx_pkg::MEM_AW;

  rvx_pkg::state_t state, state_next;

  // latched item
  rvx_pkg::op_t op;
  logic [4:0]   rd;
  logic [31:0]  imm;
  logic         illegal;

  // architectural state
  logic [31:0] pc;
  logic [31:0] rf [rvx_pkg::NUM_REGS];
  logic [rvx_pkg::NUM_REGS-1:0] rf_vld;
  logic [31:0] rf_q1, rf_q2;
  logic        rf_v1, rf_v2;
  logic [3:0][7:0] dmem [rvx_pkg::MEM_WORDS];
  logic [31:0] dm_q0, dm_q1;

  // working registers
  logic [31:0] res;
  logic [31:0] npc;

  // divider
  logic [31:0] dq, drem, dvsr;
  logic [4:0]  dcnt;
  logic        dnegq, dnegr, dzero;

  // control
  logic accept, fin_fire, dm_rd, dm_wr_lo, dm_wr_hi, div_start, rf_wr;

  // operands, register reads are stable for the whole item
  logic [31:0] a, b;
  assign a = rf_v1 ? rf_q1 : 32'd0;
  assign b = rf_v2 ? rf_q2 : 32'd0;

  // memory addressing, wraps modulo memory size
  logic [31:0]   addr;
  logic [AW-1:0] w0, w1;
  logic [1:0]    off;
  assign addr = a + imm;
  assign w0   = addr[AW+1:2];
  assign w1   = w0 + AW'(1);
  assign off  = addr[1:0];

  // store byte lanes over two words
  logic [3:0]  st_mask;
  logic [7:0]  st_en;
  logic [63:0] st_data;
  always_comb begin
    case (op)
      rvx_pkg::OP_SB: st_mask = 4'b0001;
      rvx_pkg::OP_SH: st_mask = 4'b0011;
      default:        st_mask = 4'b1111;
    endcase
    st_en   = {4'b0, st_mask} << off;
    st_data = {32'd0, b} << {off, 3'b000};
  end

  // single write port: low word in exec, spill word in the next cycle
  logic [AW-1:0] dm_wa;
  logic [3:0]    dm_be;
  logic [31:0]   dm_wd;
  assign dm_wa = dm_wr_hi ? w1 : w0;
  assign dm_be = dm_wr_hi ? st_en[7:4] : (dm_wr_lo ? st_en[3:0] : 4'd0);
  assign dm_wd = dm_wr_hi ? st_data[63:32] : st_data[31:0];

  // load extraction
  logic [63:0] ld_win;
  logic [31:0] ld_val;
  always_comb begin
    ld_win = {dm_q1, dm_q0} >> {off, 3'b000};
    case (op)
      rvx_pkg::OP_LB:  ld_val = {{24{ld_win[7]}}, ld_win[7:0]};
      rvx_pkg::OP_LH:  ld_val = {{16{ld_win[15]}}, ld_win[15:0]};
      rvx_pkg::OP_LBU: ld_val = {24'd0, ld_win[7:0]};
      rvx_pkg::OP_LHU: ld_val = {16'd0, ld_win[15:0]};
      default:         ld_val = ld_win[31:0];
    endcase
  end

  // multiplier, operands widened by one bit for signedness
  logic               ma_s, mb_s;
  logic signed [65:0] prod;
  always_comb begin
    ma_s = (op == rvx_pkg::OP_MULH) || (op == rvx_pkg::OP_MULHSU);
    mb_s = (op == rvx_pkg::OP_MULH);
    prod = $signed({ma_s & a[31], a}) * $signed({mb_s & b[31], b});
  end

  // alu, next pc, writer decode
  logic [31:0] alu_val, npc_val;
  logic        take, writes;
  always_comb begin
    alu_val = 32'd0;
    take    = 1'b0;
    writes  = 1'b1;
    case (op)
      rvx_pkg::OP_LUI:    alu_val = imm;
      rvx_pkg::OP_AUIPC:  alu_val = pc + imm;
      rvx_pkg::OP_JAL:    alu_val = pc + 32'd4;
      rvx_pkg::OP_JALR:   alu_val = pc + 32'd4;
      rvx_pkg::OP_BEQ:    begin take = (a == b); writes = 1'b0; end
      rvx_pkg::OP_BNE:    begin take = (a != b); writes = 1'b0; end
      rvx_pkg::OP_BLT:    begin take = ($signed(a) < $signed(b)); writes = 1'b0; end
      rvx_pkg::OP_BGE:    begin take = ($signed(a) >= $signed(b)); writes = 1'b0; end
      rvx_pkg::OP_BLTU:   begin take = (a < b); writes = 1'b0; end
      rvx_pkg::OP_BGEU:   begin take = (a >= b); writes = 1'b0; end
      rvx_pkg::OP_SB, rvx_pkg::OP_SH, rvx_pkg::OP_SW: writes = 1'b0;
      rvx_pkg::OP_ADDI:   alu_val = a + imm;
      rvx_pkg::OP_SLTI:   alu_val = {31'd0, $signed(a) < $signed(imm)};
      rvx_pkg::OP_SLTIU:  alu_val = {31'd0, a < imm};
      rvx_pkg::OP_XORI:   alu_val = a ^ imm;
      rvx_pkg::OP_ORI:    alu_val = a | imm;
      rvx_pkg::OP_ANDI:   alu_val = a & imm;
      rvx_pkg::OP_SLLI:   alu_val = a << imm[4:0];
      rvx_pkg::OP_SRLI:   alu_val = a >> imm[4:0];
      rvx_pkg::OP_SRAI:   alu_val = $unsigned($signed(a) >>> imm[4:0]);
      rvx_pkg::OP_ADD:    alu_val = a + b;
      rvx_pkg::OP_SUB:    alu_val = a - b;
      rvx_pkg::OP_SLL:    alu_val = a << b[4:0];
      rvx_pkg::OP_SLT:    alu_val = {31'd0, $signed(a) < $signed(b)};
      rvx_pkg::OP_SLTU:   alu_val = {31'd0, a < b};
      rvx_pkg::OP_XOR:    alu_val = a ^ b;
      rvx_pkg::OP_SRL:    alu_val = a >> b[4:0];
      rvx_pkg::OP_SRA:    alu_val = $unsigned($signed(a) >>> b[4:0]);
      rvx_pkg::OP_OR:     alu_val = a | b;
      rvx_pkg::OP_AND:    alu_val = a & b;
      rvx_pkg::OP_FENCE, rvx_pkg::OP_FENCE_TSO, rvx_pkg::OP_PAUSE,
      rvx_pkg::OP_ECALL, rvx_pkg::OP_EBREAK: writes = 1'b0;
      rvx_pkg::OP_MUL:    alu_val = prod[31:0];
      rvx_pkg::OP_MULH, rvx_pkg::OP_MULHSU, rvx_pkg::OP_MULHU:
                          alu_val = prod[63:32];
      default:            ;
    endcase
    if (illegal) writes = 1'b0;
    npc_val = pc + 32'd4;
    if (op == rvx_pkg::OP_JAL || take) npc_val = pc + imm;
    if (op == rvx_pkg::OP_JALR)        npc_val = addr & ~32'd1;
  end

  // operation classes
  logic is_load, is_store, is_div, is_quot;
  assign is_load  = (op == rvx_pkg::OP_LB) || (op == rvx_pkg::OP_LH) ||
                    (op == rvx_pkg::OP_LW) || (op == rvx_pkg::OP_LBU) ||
                    (op == rvx_pkg::OP_LHU);
  assign is_store = (op == rvx_pkg::OP_SB) || (op == rvx_pkg::OP_SH) ||
                    (op == rvx_pkg::OP_SW);
  assign is_quot  = (op == rvx_pkg::OP_DIV) || (op == rvx_pkg::OP_DIVU);
  assign is_div   = is_quot || (op == rvx_pkg::OP_REM) || (op == rvx_pkg::OP_REMU);

  // divider step
  logic [32:0] d_sh;
  logic [33:0] d_diff;
  logic        d_ge;
  logic [31:0] q_nx, r_nx, div_val;
  logic        d_sgn;
  always_comb begin
    d_sh   = {drem, dq[31]};
    d_diff = {1'b0, d_sh} - {2'b0, dvsr};
    d_ge   = !d_diff[33];
    r_nx   = d_ge ? d_diff[31:0] : d_sh[31:0];
    q_nx   = {dq[30:0], d_ge};
    if (dzero)        div_val = is_quot ? 32'hFFFF_FFFF : a;
    else if (is_quot) div_val = dnegq ? (32'd0 - q_nx) : q_nx;
    else              div_val = dnegr ? (32'd0 - r_nx) : r_nx;
    d_sgn  = (op == rvx_pkg::OP_DIV) || (op == rvx_pkg::OP_REM);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rvx_pkg::S_IDLE: if (req_valid) state_next = rvx_pkg::S_EXEC;
      rvx_pkg::S_EXEC: begin
        if (is_load || is_store) state_next = rvx_pkg::S_MEM;
        else if (is_div)         state_next = rvx_pkg::S_DIV;
        else                     state_next = rvx_pkg::S_FIN;
      end
      rvx_pkg::S_MEM:  state_next = rvx_pkg::S_FIN;
      rvx_pkg::S_DIV:  if (dcnt == 5'd31) state_next = rvx_pkg::S_FIN;
      rvx_pkg::S_FIN:  if (!rsp_valid || !rsp_stall) state_next = rvx_pkg::S_IDLE;
      default:         state_next = rvx_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_stall = 1'b1;
    dm_rd     = 1'b0;
    dm_wr_lo  = 1'b0;
    dm_wr_hi  = 1'b0;
    div_start = 1'b0;
    fin_fire  = 1'b0;
    case (state)
      rvx_pkg::S_IDLE: req_stall = 1'b0;
      rvx_pkg::S_EXEC: begin
        dm_rd     = is_load;
        dm_wr_lo  = is_store;
        div_start = is_div;
      end
      rvx_pkg::S_MEM:  dm_wr_hi = is_store;
      rvx_pkg::S_FIN:  fin_fire = !rsp_valid || !rsp_stall;
      default:         ;
    endcase
  end

  assign accept = req_valid && !req_stall;
  assign rf_wr  = fin_fire && writes && (rd != 5'd0);

  always_ff @(posedge clk) begin
    if (rst) state <= rvx_pkg::S_IDLE;
    else     state <= state_next;
  end

  // register file ram, two read ports, written at item end
  always_ff @(posedge clk) begin
    if (accept) begin
      rf_q1 <= rf[req.src1_index];
      rf_q2 <= rf[req.src2_index];
    end
    if (rf_wr) rf[rd] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
      rf_v1  <= 1'b0;
      rf_v2  <= 1'b0;
    end else begin
      if (accept) begin
        rf_v1 <= rf_vld[req.src1_index];
        rf_v2 <= rf_vld[req.src2_index];
      end
      if (rf_wr) rf_vld[rd] <= 1'b1;
    end
  end

  // data memory, byte lanes, low word written in exec and spill word after
  always_ff @(posedge clk) begin
    if (dm_rd) begin
      dm_q0 <= dmem[w0];
      dm_q1 <= dmem[w1];
    end
    for (int i = 0; i < 4; i++) begin
      if (dm_be[i]) dmem[dm_wa][i] <= dm_wd[8*i +: 8];
    end
  end

  // item latch and data path
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= rvx_pkg::op_t'(req.req_type);
      illegal <= (req.req_type > 6'(rvx_pkg::OP_REMU));
      rd      <= req.dest_index;
      imm     <= req.immediate;
    end
    if (state == rvx_pkg::S_EXEC) begin
      res <= alu_val;
      npc <= npc_val;
    end
    if (state == rvx_pkg::S_MEM && is_load) res <= ld_val;
    if (div_start) begin
      dq    <= (d_sgn && a[31]) ? (32'd0 - a) : a;
      dvsr  <= (d_sgn && b[31]) ? (32'd0 - b) : b;
      drem  <= 32'd0;
      dcnt  <= 5'd0;
      dnegq <= d_sgn && (a[31] ^ b[31]);
      dnegr <= d_sgn && a[31];
      dzero <= (b == 32'd0);
    end else if (state == rvx_pkg::S_DIV) begin
      dq   <= q_nx;
      drem <= r_nx;
      dcnt <= dcnt + 5'd1;
      if (dcnt == 5'd31) res <= div_val;
    end
  end

  // pc and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= 32'd0;
      rsp_valid <= 1'b0;
    end else begin
      if (fin_fire) begin
        pc        <= npc;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      rsp.next_pc       <= npc;
      rsp.reg_written   <= writes && (rd != 5'd0);
      rsp.written_index <= (writes && (rd != 5'd0)) ? rd : 5'd0;
      rsp.written_value <= (writes && (rd != 5'd0)) ? res : 32'd0;
      rsp.illegal_op    <= illegal;
    end
  end

  // checks
  a_x0_never_valid: assert property (@(posedge clk) disable iff (rst)
    !rf_vld[0])
    else $error("register x0 marked written");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == rvx_pkg::S_EXEC))
    else $error("accepted item did not enter execute");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == rvx_pkg::S_DIV && dcnt == 5'd31) |=> (state == rvx_pkg::S_FIN))
    else $error("divider did not finish after 32 steps");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == rvx_pkg::S_FIN && rsp_valid && rsp_stall) |=> (state == rvx_pkg::S_FIN))
    else $error("result overwrote a stalled output item");

endmodule
